@@ hw/rtl/array_machine_instruction_executor_macros.svh @@
// Assertion macros used by the array machine controller.
// Define NO_ASSERTIONS to compile the checks out; no other dependencies.
`ifndef ARRAY_MACHINE_INSTRUCTION_EXECUTOR_MACROS_SVH
`define ARRAY_MACHINE_INSTRUCTION_EXECUTOR_MACROS_SVH
`ifndef NO_ASSERTIONS
`define AMIE_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("array machine assertion failed");
`define AMIE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("array machine assertion failed");
`else
`define AMIE_ASSERT(lbl, clk, rst_n, prop)
`define AMIE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ hw/rtl/amie_pkg.sv @@
// Package for the array machine: transaction payloads, opcodes, fault codes,
// and the command and status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package amie_pkg;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EXEC = 1'b1;

    localparam logic [3:0] OP_CMOV     = 4'd0;
    localparam logic [3:0] OP_INDEX    = 4'd1;
    localparam logic [3:0] OP_AMEND    = 4'd2;
    localparam logic [3:0] OP_ADD      = 4'd3;
    localparam logic [3:0] OP_MUL      = 4'd4;
    localparam logic [3:0] OP_DIV      = 4'd5;
    localparam logic [3:0] OP_NAND     = 4'd6;
    localparam logic [3:0] OP_HALT     = 4'd7;
    localparam logic [3:0] OP_ALLOC    = 4'd8;
    localparam logic [3:0] OP_FREE     = 4'd9;
    localparam logic [3:0] OP_OUTPUT   = 4'd10;
    localparam logic [3:0] OP_INPUT    = 4'd11;
    localparam logic [3:0] OP_LOADPROG = 4'd12;
    localparam logic [3:0] OP_IMM      = 4'd13;

    localparam logic [3:0] FLT_NONE    = 4'd0;
    localparam logic [3:0] FLT_PC      = 4'd1;
    localparam logic [3:0] FLT_OPCODE  = 4'd2;
    localparam logic [3:0] FLT_ID      = 4'd3;
    localparam logic [3:0] FLT_OFFSET  = 4'd4;
    localparam logic [3:0] FLT_DIVZERO = 4'd5;
    localparam logic [3:0] FLT_ROOM    = 4'd6;
    localparam logic [3:0] FLT_CHAR    = 4'd7;
    localparam logic [3:0] FLT_FREE0   = 4'd8;

    localparam logic [31:0] EOF_WORD  = 32'hFFFF_FFFF;
    localparam logic [31:0] CHAR_MAX  = 32'd255;
    localparam int          REG_COUNT = 8;

    typedef struct packed {
        logic        cmd;
        logic [31:0] load_word;
        logic [7:0]  in_char;
        logic        in_eof;
    } t_in_item;

    typedef struct packed {
        logic        out_valid;
        logic [7:0]  out_char;
        logic        input_used;
        logic        halted;
        logic [3:0]  fault;
        logic [31:0] next_pc;
    } t_out_item;

    typedef enum logic [4:0] {
        UOP_NONE, UOP_CLEAR, UOP_TAKE, UOP_LOAD, UOP_FETCH, UOP_DECODE, UOP_READ,
        UOP_REGWR, UOP_TABRD, UOP_MEMRD, UOP_MEMWR, UOP_MEMWB, UOP_DIVINIT,
        UOP_DIVSTEP, UOP_HALT, UOP_POP, UOP_ALLOC, UOP_FREE, UOP_OUTPUT, UOP_JUMP,
        UOP_COPYINIT, UOP_COPY, UOP_PROGSET, UOP_PCINC, UOP_FAULT, UOP_RESULT
    } t_uop;

    typedef struct packed {
        t_uop       uop;
        logic [3:0] fault;
    } t_dp_cmd;

    typedef struct packed {
        logic       clear_done;
        logic       stopped;
        logic       started;
        logic       is_exec;
        logic       store_full;
        logic       pc_bad;
        logic [3:0] op;
        logic       op_bad;
        logic       x_zero;
        logic       y_zero;
        logic       y_big;
        logic       room_bad;
        logic       id_fault;
        logic       off_bad;
        logic       stack_empty;
        logic       ids_out;
        logic       div_done;
        logic       copy_done;
        logic       out_busy;
    } t_dp_status;

endpackage
`default_nettype wire

@@ hw/rtl/amie_stream_if.sv @@
// Valid/ready stream interface that carries one payload per transaction.
// The payload type is a parameter; used with the types of amie_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface amie_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/array_machine_instruction_executor.sv @@
// Divide produces one quotient bit a cycle; a program load copies one word a
// cycle through the word store port.
// One transaction at a time; a new input is taken only after the previous
// result has been accepted.
// After reset a clearing pass over the word store, array table and registers runs first.
`timescale 1ns / 1ps
`default_nettype none
module array_machine_instruction_executor #(
    parameter int STORE_WORDS = 65536,
    parameter int MAX_ARRAYS  = 1024
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    amie_stream_if.sink   i_in,
    amie_stream_if.source o_out
);
    amie_pkg::t_dp_cmd    cmd;
    amie_pkg::t_dp_status status;
    amie_pkg::t_out_item  out_item;
    logic                 in_ready;
    logic                 out_valid;

    amie_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_status   (status),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    amie_dp #(
        .STORE_WORDS (STORE_WORDS),
        .MAX_ARRAYS  (MAX_ARRAYS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_item      (i_in.data),
        .i_out_ready (o_out.ready),
        .o_status    (status),
        .o_out_valid (out_valid),
        .o_out_item  (out_item)
    );

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;
    assign o_out.data  = out_item;
endmodule
`default_nettype wire

@@ hw/rtl/amie_dp.sv @@
// Datapath of the array machine: register file, word store, array table,
// free id stack, divider, copy engine and result register. Uses amie_pkg.
`timescale 1ns / 1ps
`default_nettype none
module amie_dp #(
    parameter int STORE_WORDS = 65536,
    parameter int MAX_ARRAYS  = 1024
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire amie_pkg::t_dp_cmd     i_cmd,
    input  wire amie_pkg::t_in_item    i_item,
    input  wire logic                  i_out_ready,
    output amie_pkg::t_dp_status       o_status,
    output logic                       o_out_valid,
    output amie_pkg::t_out_item        o_out_item
);
    localparam int SW    = $clog2(STORE_WORDS);
    localparam int LW    = $clog2(STORE_WORDS + 1);
    localparam int AW    = $clog2(MAX_ARRAYS);
    localparam int CW    = $clog2(MAX_ARRAYS + 1);
    localparam int CLR_N = (STORE_WORDS > MAX_ARRAYS) ? STORE_WORDS : MAX_ARRAYS;
    localparam int CLRW  = $clog2(CLR_N);
    localparam logic [LW-1:0] STORE_LIM  = LW'(STORE_WORDS);
    localparam logic [32:0]   STORE_WIDE = 33'(STORE_WORDS);
    localparam logic [CW-1:0] ID_LIM     = CW'(MAX_ARRAYS);

    typedef struct packed {
        logic          live;
        logic [LW-1:0] base;
        logic [LW-1:0] len;
    } t_arec;

    logic [31:0] r_wmem [STORE_WORDS];
    t_arec       r_atab [MAX_ARRAYS];
    logic [AW-1:0] r_fstk [MAX_ARRAYS];
    logic [31:0] r_rf [amie_pkg::REG_COUNT];

    logic [31:0]   r_pc;
    logic          r_stopped, r_started;
    logic [LW-1:0] r_base0, r_len0, r_bump;
    logic [CW-1:0] r_fcnt, r_nextid;
    logic [CLRW-1:0] r_clr;
    logic          r_ov;
    logic [LW-1:0] r_ci, r_cwi;
    logic          r_cpend;
    logic [5:0]    r_dcnt;

    amie_pkg::t_in_item  r_item;
    amie_pkg::t_out_item r_out;
    logic [31:0]   r_ins, r_x, r_y, r_z, r_wrd, r_dq, r_drem;
    t_arec         r_atrd;
    logic          r_at_oob, r_at_zero;
    logic [AW-1:0] r_fsrd;
    logic [3:0]    r_fault;
    logic          r_oval, r_iused;
    logic [7:0]    r_ochar;

    logic [3:0]    op;
    logic [2:0]    fa, fb, fc, fr;
    logic [31:0]   id_sel;
    logic          at_live;
    logic [LW-1:0] at_base, at_len, free_room;
    logic [32:0]   slot_sum, pc_sum, dv_t;
    logic [LW:0]   src_end, src_addr, dst_addr;
    logic          room_bad, dv_ge;
    logic [AW-1:0] alloc_id;
    logic [CW-1:0] fidx_pop;
    logic [31:0]   mul_lo;

    logic          wm_we, wm_re, rf_we;
    logic [SW-1:0] wm_wa, wm_ra;
    logic [31:0]   wm_wd, rf_wd;
    logic [2:0]    rf_wa;

    assign op = r_ins[31:28];
    assign fa = r_ins[8:6];
    assign fb = r_ins[5:3];
    assign fc = r_ins[2:0];
    assign fr = r_ins[27:25];

    assign id_sel   = (op == amie_pkg::OP_FREE) ? r_y : r_x;
    assign at_live  = !r_at_oob && (r_at_zero || r_atrd.live);
    assign at_base  = r_at_zero ? r_base0 : r_atrd.base;
    assign at_len   = r_at_zero ? r_len0 : r_atrd.len;
    assign free_room = STORE_LIM - r_bump;
    assign slot_sum = 33'(at_base) + 33'(r_y);
    assign pc_sum   = 33'(r_base0) + 33'(r_pc);
    assign src_end  = {1'b0, at_base} + {1'b0, at_len};
    assign src_addr = {1'b0, at_base} + {1'b0, r_ci};
    assign dst_addr = {1'b0, r_bump} + {1'b0, r_cwi};
    assign alloc_id = (r_fcnt != '0) ? r_fsrd : r_nextid[AW-1:0];
    assign fidx_pop = r_fcnt - CW'(1);
    assign mul_lo   = r_x * r_y;
    assign dv_t     = {r_drem, r_dq[31]};
    assign dv_ge    = dv_t >= {1'b0, r_y};

    always_comb begin
        if (op == amie_pkg::OP_ALLOC) begin
            room_bad = {1'b0, r_y} > 33'(free_room);
        end else begin
            room_bad = (at_len > free_room) || (src_end > (LW + 1)'(STORE_WORDS));
        end
    end

    always_comb begin
        wm_we = 1'b0;
        wm_wa = '0;
        wm_wd = '0;
        wm_re = 1'b0;
        wm_ra = '0;
        case (i_cmd.uop)
            amie_pkg::UOP_CLEAR: begin
                wm_we = 32'(r_clr) < 32'(STORE_WORDS);
                wm_wa = r_clr[SW-1:0];
            end
            amie_pkg::UOP_LOAD: begin
                wm_we = 1'b1;
                wm_wa = r_bump[SW-1:0];
                wm_wd = r_item.load_word;
            end
            amie_pkg::UOP_FETCH: begin
                wm_re = 1'b1;
                wm_ra = pc_sum[SW-1:0];
            end
            amie_pkg::UOP_MEMRD: begin
                wm_re = 1'b1;
                wm_ra = slot_sum[SW-1:0];
            end
            amie_pkg::UOP_MEMWR: begin
                wm_we = 1'b1;
                wm_wa = slot_sum[SW-1:0];
                wm_wd = r_z;
            end
            amie_pkg::UOP_COPY: begin
                wm_re = r_ci < at_len;
                wm_ra = src_addr[SW-1:0];
                wm_we = r_cpend;
                wm_wa = dst_addr[SW-1:0];
                wm_wd = r_wrd;
            end
            default: begin
                wm_we = 1'b0;
            end
        endcase
    end

    always_comb begin
        rf_we = 1'b0;
        rf_wa = fa;
        rf_wd = '0;
        case (i_cmd.uop)
            amie_pkg::UOP_CLEAR: begin
                rf_we = r_clr < CLRW'(amie_pkg::REG_COUNT);
                rf_wa = r_clr[2:0];
            end
            amie_pkg::UOP_MEMWB: begin
                rf_we = 1'b1;
                rf_wd = r_wrd;
            end
            amie_pkg::UOP_ALLOC: begin
                rf_we = 1'b1;
                rf_wa = fb;
                rf_wd = 32'(alloc_id);
            end
            amie_pkg::UOP_REGWR: begin
                rf_we = 1'b1;
                case (op)
                    amie_pkg::OP_CMOV: begin
                        rf_we = r_y != '0;
                        rf_wd = r_x;
                    end
                    amie_pkg::OP_ADD:  rf_wd = r_x + r_y;
                    amie_pkg::OP_MUL:  rf_wd = mul_lo;
                    amie_pkg::OP_DIV:  rf_wd = r_dq;
                    amie_pkg::OP_NAND: rf_wd = ~(r_x & r_y);
                    amie_pkg::OP_IMM: begin
                        rf_wa = fr;
                        rf_wd = {7'b0, r_ins[24:0]};
                    end
                    amie_pkg::OP_INPUT: begin
                        rf_wa = fc;
                        rf_wd = r_item.in_eof ? amie_pkg::EOF_WORD
                                              : {24'b0, r_item.in_char};
                    end
                    default: rf_we = 1'b0;
                endcase
            end
            default: begin
                rf_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wm_we) begin
            r_wmem[wm_wa] <= wm_wd;
        end
        if (wm_re) begin
            r_wrd <= r_wmem[wm_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rf_we) begin
            r_rf[rf_wa] <= rf_wd;
        end
        if (i_cmd.uop == amie_pkg::UOP_READ) begin
            r_x <= r_rf[(op == amie_pkg::OP_AMEND) ? fa : fb];
            r_y <= r_rf[(op == amie_pkg::OP_AMEND) ? fb : fc];
        end
        if (i_cmd.uop == amie_pkg::UOP_TABRD) begin
            r_z <= r_rf[fc];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.uop == amie_pkg::UOP_CLEAR && 32'(r_clr) < 32'(MAX_ARRAYS)) begin
            r_atab[r_clr[AW-1:0]] <= '0;
        end else if (i_cmd.uop == amie_pkg::UOP_ALLOC) begin
            r_atab[alloc_id] <= '{live: 1'b1, base: r_bump, len: LW'(r_y)};
        end else if (i_cmd.uop == amie_pkg::UOP_FREE) begin
            r_atab[id_sel[AW-1:0]] <= '0;
        end
        if (i_cmd.uop == amie_pkg::UOP_TABRD) begin
            r_atrd    <= r_atab[id_sel[AW-1:0]];
            r_at_oob  <= id_sel >= 32'(MAX_ARRAYS);
            r_at_zero <= id_sel == '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.uop == amie_pkg::UOP_FREE && r_fcnt < ID_LIM) begin
            r_fstk[r_fcnt[AW-1:0]] <= id_sel[AW-1:0];
        end
        if (i_cmd.uop == amie_pkg::UOP_POP) begin
            r_fsrd <= r_fstk[fidx_pop[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc      <= '0;
            r_stopped <= 1'b0;
            r_started <= 1'b0;
            r_base0   <= '0;
            r_len0    <= '0;
            r_bump    <= '0;
            r_fcnt    <= '0;
            r_nextid  <= CW'(1);
            r_clr     <= '0;
            r_ov      <= 1'b0;
            r_ci      <= '0;
            r_cwi     <= '0;
            r_cpend   <= 1'b0;
            r_dcnt    <= '0;
        end else begin
            if (r_ov && i_out_ready) begin
                r_ov <= 1'b0;
            end
            case (i_cmd.uop)
                amie_pkg::UOP_CLEAR: r_clr <= r_clr + CLRW'(1);
                amie_pkg::UOP_LOAD: begin
                    r_bump <= r_bump + LW'(1);
                    r_len0 <= r_len0 + LW'(1);
                end
                amie_pkg::UOP_FETCH:   r_started <= 1'b1;
                amie_pkg::UOP_DIVINIT: r_dcnt <= '0;
                amie_pkg::UOP_DIVSTEP: r_dcnt <= r_dcnt + 6'd1;
                amie_pkg::UOP_HALT:    r_stopped <= 1'b1;
                amie_pkg::UOP_FAULT:   r_stopped <= 1'b1;
                amie_pkg::UOP_ALLOC: begin
                    r_bump <= r_bump + LW'(r_y);
                    if (r_fcnt != '0) begin
                        r_fcnt <= fidx_pop;
                    end else begin
                        r_nextid <= r_nextid + CW'(1);
                    end
                end
                amie_pkg::UOP_FREE: begin
                    if (r_fcnt < ID_LIM) begin
                        r_fcnt <= r_fcnt + CW'(1);
                    end
                end
                amie_pkg::UOP_JUMP: r_pc <= r_y;
                amie_pkg::UOP_COPYINIT: begin
                    r_ci    <= '0;
                    r_cpend <= 1'b0;
                end
                amie_pkg::UOP_COPY: begin
                    if (r_ci < at_len) begin
                        r_ci <= r_ci + LW'(1);
                    end
                    r_cpend <= r_ci < at_len;
                    r_cwi   <= r_ci;
                end
                amie_pkg::UOP_PROGSET: begin
                    r_base0 <= r_bump;
                    r_len0  <= at_len;
                    r_bump  <= r_bump + at_len;
                    r_pc    <= r_y;
                end
                amie_pkg::UOP_PCINC:  r_pc <= r_pc + 32'd1;
                amie_pkg::UOP_RESULT: r_ov <= 1'b1;
                default: begin
                    r_ov <= r_ov && !i_out_ready;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.uop)
            amie_pkg::UOP_TAKE: begin
                r_item  <= i_item;
                r_fault <= amie_pkg::FLT_NONE;
                r_oval  <= 1'b0;
                r_ochar <= '0;
                r_iused <= 1'b0;
            end
            amie_pkg::UOP_DECODE: r_ins <= r_wrd;
            amie_pkg::UOP_DIVINIT: begin
                r_dq   <= r_x;
                r_drem <= '0;
            end
            amie_pkg::UOP_DIVSTEP: begin
                r_dq   <= {r_dq[30:0], dv_ge};
                r_drem <= dv_ge ? 32'(dv_t - {1'b0, r_y}) : dv_t[31:0];
            end
            amie_pkg::UOP_OUTPUT: begin
                r_oval  <= 1'b1;
                r_ochar <= r_y[7:0];
            end
            amie_pkg::UOP_REGWR: begin
                if (op == amie_pkg::OP_INPUT) begin
                    r_iused <= 1'b1;
                end
            end
            amie_pkg::UOP_FAULT: begin
                r_fault <= i_cmd.fault;
                r_oval  <= 1'b0;
                r_ochar <= '0;
                r_iused <= 1'b0;
            end
            amie_pkg::UOP_RESULT: begin
                r_out <= '{out_valid: r_oval, out_char: r_ochar, input_used: r_iused,
                           halted: r_stopped, fault: r_fault, next_pc: r_pc};
            end
            default: begin
                r_out <= r_out;
            end
        endcase
    end

    assign o_status = '{
        clear_done:  r_clr == CLRW'(CLR_N - 1),
        stopped:     r_stopped,
        started:     r_started,
        is_exec:     r_item.cmd == amie_pkg::CMD_EXEC,
        store_full:  r_bump >= STORE_LIM,
        pc_bad:      ({1'b0, r_pc} >= 33'(r_len0)) || (pc_sum >= STORE_WIDE),
        op:          op,
        op_bad:      op > amie_pkg::OP_IMM,
        x_zero:      r_x == '0,
        y_zero:      r_y == '0,
        y_big:       r_y > amie_pkg::CHAR_MAX,
        room_bad:    room_bad,
        id_fault:    !at_live,
        off_bad:     ({1'b0, r_y} >= 33'(at_len)) || (slot_sum >= STORE_WIDE),
        stack_empty: r_fcnt == '0,
        ids_out:     r_nextid >= ID_LIM,
        div_done:    r_dcnt == 6'd32,
        copy_done:   (r_ci == at_len) && !r_cpend,
        out_busy:    r_ov
    };

    assign o_out_valid = r_ov;
    assign o_out_item  = r_out;
endmodule
`default_nettype wire

@@ hw/rtl/amie_ctrl.sv @@
// Controller of the array machine: sequences each transaction through the
// datapath with micro-operations. Uses amie_pkg and the assertion macros.
`timescale 1ns / 1ps
`default_nettype none
`include "array_machine_instruction_executor_macros.svh"
module amie_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    input  wire amie_pkg::t_dp_status i_status,
    output logic                      o_in_ready,
    output amie_pkg::t_dp_cmd         o_cmd
);
    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_DISP, S_DEC, S_READ, S_EXEC, S_LOC, S_WB, S_DIV,
        S_ALLOC, S_FREE, S_PROG, S_COPY, S_FIN, S_RES
    } t_state;

    t_state r_state, n_state;

    assign o_in_ready = (r_state == S_IDLE) && !i_status.out_busy;

    always_comb begin
        n_state     = r_state;
        o_cmd.uop   = amie_pkg::UOP_NONE;
        o_cmd.fault = amie_pkg::FLT_NONE;
        unique case (r_state)
            S_CLR: begin
                o_cmd.uop = amie_pkg::UOP_CLEAR;
                if (i_status.clear_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    o_cmd.uop = amie_pkg::UOP_TAKE;
                    n_state   = S_DISP;
                end
            end
            S_DISP: begin
                n_state = S_RES;
                if (i_status.stopped) begin
                    o_cmd.uop = amie_pkg::UOP_NONE;
                end else if (!i_status.is_exec) begin
                    if (i_status.started) begin
                        o_cmd.uop = amie_pkg::UOP_NONE;
                    end else if (i_status.store_full) begin
                        o_cmd.uop   = amie_pkg::UOP_FAULT;
                        o_cmd.fault = amie_pkg::FLT_ROOM;
                    end else begin
                        o_cmd.uop = amie_pkg::UOP_LOAD;
                    end
                end else begin
                    o_cmd.uop = amie_pkg::UOP_FETCH;
                    n_state   = S_DEC;
                end
            end
            S_DEC: begin
                if (i_status.pc_bad) begin
                    o_cmd.uop   = amie_pkg::UOP_FAULT;
                    o_cmd.fault = amie_pkg::FLT_PC;
                    n_state     = S_RES;
                end else begin
                    o_cmd.uop = amie_pkg::UOP_DECODE;
                    n_state   = S_READ;
                end
            end
            S_READ: begin
                if (i_status.op_bad) begin
                    o_cmd.uop   = amie_pkg::UOP_FAULT;
                    o_cmd.fault = amie_pkg::FLT_OPCODE;
                    n_state     = S_RES;
                end else begin
                    o_cmd.uop = amie_pkg::UOP_READ;
                    n_state   = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_FIN;
                case (i_status.op)
                    amie_pkg::OP_CMOV, amie_pkg::OP_ADD, amie_pkg::OP_MUL,
                    amie_pkg::OP_NAND, amie_pkg::OP_IMM, amie_pkg::OP_INPUT: begin
                        o_cmd.uop = amie_pkg::UOP_REGWR;
                    end
                    amie_pkg::OP_INDEX, amie_pkg::OP_AMEND: begin
                        o_cmd.uop = amie_pkg::UOP_TABRD;
                        n_state   = S_LOC;
                    end
                    amie_pkg::OP_DIV: begin
                        if (i_status.y_zero) begin
                            o_cmd.uop   = amie_pkg::UOP_FAULT;
                            o_cmd.fault = amie_pkg::FLT_DIVZERO;
                            n_state     = S_RES;
                        end else begin
                            o_cmd.uop = amie_pkg::UOP_DIVINIT;
                            n_state   = S_DIV;
                        end
                    end
                    amie_pkg::OP_HALT: begin
                        o_cmd.uop = amie_pkg::UOP_HALT;
                        n_state   = S_RES;
                    end
                    amie_pkg::OP_ALLOC: begin
                        if (i_status.room_bad) begin
                            o_cmd.uop   = amie_pkg::UOP_FAULT;
                            o_cmd.fault = amie_pkg::FLT_ROOM;
                            n_state     = S_RES;
                        end else if (!i_status.stack_empty) begin
                            o_cmd.uop = amie_pkg::UOP_POP;
                            n_state   = S_ALLOC;
                        end else if (i_status.ids_out) begin
                            o_cmd.uop   = amie_pkg::UOP_FAULT;
                            o_cmd.fault = amie_pkg::FLT_ROOM;
                            n_state     = S_RES;
                        end else begin
                            n_state = S_ALLOC;
                        end
                    end
                    amie_pkg::OP_FREE: begin
                        if (i_status.y_zero) begin
                            o_cmd.uop   = amie_pkg::UOP_FAULT;
                            o_cmd.fault = amie_pkg::FLT_FREE0;
                            n_state     = S_RES;
                        end else begin
                            o_cmd.uop = amie_pkg::UOP_TABRD;
                            n_state   = S_FREE;
                        end
                    end
                    amie_pkg::OP_OUTPUT: begin
                        if (i_status.y_big) begin
                            o_cmd.uop   = amie_pkg::UOP_FAULT;
                            o_cmd.fault = amie_pkg::FLT_CHAR;
                            n_state     = S_RES;
                        end else begin
                            o_cmd.uop = amie_pkg::UOP_OUTPUT;
                        end
                    end
                    amie_pkg::OP_LOADPROG: begin
                        if (i_status.x_zero) begin
                            o_cmd.uop = amie_pkg::UOP_JUMP;
                            n_state   = S_RES;
                        end else begin
                            o_cmd.uop = amie_pkg::UOP_TABRD;
                            n_state   = S_PROG;
                        end
                    end
                    default: begin
                        n_state = S_RES;
                    end
                endcase
            end
            S_LOC: begin
                if (i_status.id_fault) begin
                    o_cmd.uop   = amie_pkg::UOP_FAULT;
                    o_cmd.fault = amie_pkg::FLT_ID;
                    n_state     = S_RES;
                end else if (i_status.off_bad) begin
                    o_cmd.uop   = amie_pkg::UOP_FAULT;
                    o_cmd.fault = amie_pkg::FLT_OFFSET;
                    n_state     = S_RES;
                end else if (i_status.op == amie_pkg::OP_INDEX) begin
                    o_cmd.uop = amie_pkg::UOP_MEMRD;
                    n_state   = S_WB;
                end else begin
                    o_cmd.uop = amie_pkg::UOP_MEMWR;
                    n_state   = S_FIN;
                end
            end
            S_WB: begin
                o_cmd.uop = amie_pkg::UOP_MEMWB;
                n_state   = S_FIN;
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    o_cmd.uop = amie_pkg::UOP_REGWR;
                    n_state   = S_FIN;
                end else begin
                    o_cmd.uop = amie_pkg::UOP_DIVSTEP;
                end
            end
            S_ALLOC: begin
                o_cmd.uop = amie_pkg::UOP_ALLOC;
                n_state   = S_FIN;
            end
            S_FREE: begin
                if (i_status.id_fault) begin
                    o_cmd.uop   = amie_pkg::UOP_FAULT;
                    o_cmd.fault = amie_pkg::FLT_ID;
                    n_state     = S_RES;
                end else begin
                    o_cmd.uop = amie_pkg::UOP_FREE;
                    n_state   = S_FIN;
                end
            end
            S_PROG: begin
                if (i_status.id_fault) begin
                    o_cmd.uop   = amie_pkg::UOP_FAULT;
                    o_cmd.fault = amie_pkg::FLT_ID;
                    n_state     = S_RES;
                end else if (i_status.room_bad) begin
                    o_cmd.uop   = amie_pkg::UOP_FAULT;
                    o_cmd.fault = amie_pkg::FLT_ROOM;
                    n_state     = S_RES;
                end else begin
                    o_cmd.uop = amie_pkg::UOP_COPYINIT;
                    n_state   = S_COPY;
                end
            end
            S_COPY: begin
                if (i_status.copy_done) begin
                    o_cmd.uop = amie_pkg::UOP_PROGSET;
                    n_state   = S_RES;
                end else begin
                    o_cmd.uop = amie_pkg::UOP_COPY;
                end
            end
            S_FIN: begin
                o_cmd.uop = amie_pkg::UOP_PCINC;
                n_state   = S_RES;
            end
            S_RES: begin
                o_cmd.uop = amie_pkg::UOP_RESULT;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_CLR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    `AMIE_ASSERT_NEXT(a_take_dispatch, i_clk, i_rst_n, i_in_valid && o_in_ready, r_state == S_DISP)
    `AMIE_ASSERT(a_result_slot_free, i_clk, i_rst_n, (o_cmd.uop == amie_pkg::UOP_RESULT) |-> !i_status.out_busy)
    `AMIE_ASSERT(a_copy_after_start, i_clk, i_rst_n, (o_cmd.uop == amie_pkg::UOP_COPY) |-> i_status.started)
endmodule
`default_nettype wire

@@ verif/array_machine_instruction_executor_checker.sv @@
// Checker for the array machine: watches both stream channels, predicts each result
// and compares it field by field. Depends on amie_pkg and amie_stream_if.
`timescale 1ns / 1ps
module array_machine_instruction_executor_checker
    import amie_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    amie_stream_if in_ch,
    amie_stream_if out_ch,
    output int    o_fail_count,
    output int    o_pending,
    output int    o_exec_count,
    output int    o_char_count
);
    localparam int STORE_WORDS = 65536;
    localparam int MAX_ARRAYS  = 1024;

    logic [31:0] gpr [0:7];
    logic [31:0] pc;
    logic        halt_flag;
    logic        run_seen;
    logic [31:0] words [0:STORE_WORDS-1];
    logic [31:0] arr_base [0:MAX_ARRAYS-1];
    logic [31:0] arr_len [0:MAX_ARRAYS-1];
    logic        arr_live [0:MAX_ARRAYS-1];
    logic [31:0] id_stack [0:MAX_ARRAYS-1];
    int unsigned id_depth;
    int unsigned fresh_id;
    int unsigned bump;
    t_out_item   expected_results [$];

    function automatic logic live_id(input logic [31:0] id);
        return id < MAX_ARRAYS && arr_live[id];
    endfunction

    function automatic logic fits(input logic [31:0] n);
        return 64'(n) <= 64'(STORE_WORDS) - 64'(bump);
    endfunction

    function automatic logic [3:0] find_slot(input logic [31:0] id, input logic [31:0] off,
                                             output logic [31:0] slot);
        slot = 0;
        if (!live_id(id)) return FLT_ID;
        if (off >= arr_len[id]) return FLT_OFFSET;
        if (64'(arr_base[id]) + 64'(off) >= 64'(STORE_WORDS)) return FLT_OFFSET;
        slot = arr_base[id] + off;
        return FLT_NONE;
    endfunction

    function automatic logic [3:0] execute_word(input t_in_item it, inout t_out_item res);
        logic [31:0] ins;
        logic [31:0] slot;
        logic [31:0] n;
        logic [31:0] id;
        logic [31:0] src;
        logic [3:0]  op;
        logic [3:0]  f;
        logic [2:0]  a;
        logic [2:0]  b;
        logic [2:0]  c;
        if (pc >= arr_len[0]) return FLT_PC;
        if (64'(arr_base[0]) + 64'(pc) >= 64'(STORE_WORDS)) return FLT_PC;
        ins = words[arr_base[0] + pc];
        op = ins[31:28];
        if (op > OP_IMM) return FLT_OPCODE;
        a = ins[8:6];
        b = ins[5:3];
        c = ins[2:0];
        case (op)
            OP_CMOV: if (gpr[c] != 0) gpr[a] = gpr[b];
            OP_INDEX: begin
                f = find_slot(gpr[b], gpr[c], slot);
                if (f != FLT_NONE) return f;
                gpr[a] = words[slot];
            end
            OP_AMEND: begin
                f = find_slot(gpr[a], gpr[b], slot);
                if (f != FLT_NONE) return f;
                words[slot] = gpr[c];
            end
            OP_ADD: gpr[a] = gpr[b] + gpr[c];
            OP_MUL: gpr[a] = gpr[b] * gpr[c];
            OP_DIV: begin
                if (gpr[c] == 0) return FLT_DIVZERO;
                gpr[a] = gpr[b] / gpr[c];
            end
            OP_NAND: gpr[a] = ~(gpr[b] & gpr[c]);
            OP_HALT: begin
                halt_flag = 1'b1;
                return FLT_NONE;
            end
            OP_ALLOC: begin
                n = gpr[c];
                if (!fits(n)) return FLT_ROOM;
                if (id_depth > 0) begin
                    id = id_stack[id_depth - 1];
                    id_depth--;
                end else if (fresh_id < MAX_ARRAYS) begin
                    id = fresh_id;
                    fresh_id++;
                end else begin
                    return FLT_ROOM;
                end
                arr_base[id] = bump;
                arr_len[id] = n;
                arr_live[id] = 1'b1;
                bump += n;
                gpr[b] = id;
            end
            OP_FREE: begin
                id = gpr[c];
                if (id == 0) return FLT_FREE0;
                if (!live_id(id)) return FLT_ID;
                arr_live[id] = 1'b0;
                arr_len[id] = 0;
                if (id_depth < MAX_ARRAYS) begin
                    id_stack[id_depth] = id;
                    id_depth++;
                end
            end
            OP_OUTPUT: begin
                if (gpr[c] > CHAR_MAX) return FLT_CHAR;
                res.out_valid = 1'b1;
                res.out_char = gpr[c][7:0];
            end
            OP_INPUT: begin
                gpr[c] = it.in_eof ? EOF_WORD : {24'd0, it.in_char};
                res.input_used = 1'b1;
            end
            OP_LOADPROG: begin
                id = gpr[b];
                if (id != 0) begin
                    if (!live_id(id)) return FLT_ID;
                    n = arr_len[id];
                    src = arr_base[id];
                    if (!fits(n)) return FLT_ROOM;
                    if (64'(src) + 64'(n) > 64'(STORE_WORDS)) return FLT_ROOM;
                    for (int unsigned k = 0; k < n; k++) words[bump + k] = words[src + k];
                    arr_base[0] = bump;
                    arr_len[0] = n;
                    bump += n;
                end
                pc = gpr[c];
                return FLT_NONE;
            end
            default: gpr[ins[27:25]] = {7'd0, ins[24:0]};
        endcase
        pc = pc + 1;
        return FLT_NONE;
    endfunction

    function automatic t_out_item predict_status(input t_in_item it);
        t_out_item  res;
        logic [3:0] f;
        res = '0;
        f = FLT_NONE;
        if (!halt_flag) begin
            if (it.cmd == CMD_LOAD) begin
                if (!run_seen) begin
                    if (bump >= STORE_WORDS) begin
                        f = FLT_ROOM;
                    end else begin
                        words[bump] = it.load_word;
                        bump++;
                        arr_base[0] = 0;
                        arr_len[0] = arr_len[0] + 1;
                    end
                end
            end else begin
                run_seen = 1'b1;
                f = execute_word(it, res);
            end
            if (f != FLT_NONE) begin
                halt_flag = 1'b1;
                res.out_valid = 1'b0;
                res.out_char = 8'd0;
                res.input_used = 1'b0;
            end
        end
        res.halted = halt_flag;
        res.fault = f;
        res.next_pc = pc;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item got;
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) gpr[i] = 0;
            for (int i = 0; i < STORE_WORDS; i++) words[i] = 0;
            for (int i = 0; i < MAX_ARRAYS; i++) begin
                arr_base[i] = 0;
                arr_len[i] = 0;
                arr_live[i] = (i == 0);
            end
            pc = 0;
            halt_flag = 1'b0;
            run_seen = 1'b0;
            id_depth = 0;
            fresh_id = 1;
            bump = 0;
            expected_results.delete();
            o_fail_count <= 0;
            o_exec_count <= 0;
            o_char_count <= 0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                want = predict_status(in_ch.data);
                expected_results.push_back(want);
                if (in_ch.data.cmd == CMD_EXEC) o_exec_count <= o_exec_count + 1;
                if (want.out_valid) o_char_count <= o_char_count + 1;
            end
            if (out_ch.valid && out_ch.ready) begin
                got = out_ch.data;
                if (expected_results.size() == 0) begin
                    $display("%0t: result with nothing expected: %p", $time, got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (got.out_valid !== want.out_valid || got.out_char !== want.out_char
                            || got.input_used !== want.input_used
                            || got.halted !== want.halted || got.fault !== want.fault
                            || got.next_pc !== want.next_pc) begin
                        $display("%0t: mismatch, expected %p, actual %p", $time, want, got);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
        o_pending <= expected_results.size();
    end
endmodule

@@ verif/array_machine_instruction_executor_tb.sv @@
// Testbench top for the array machine: loads a generated program, then steps it with
// execute transactions under random idling. Depends on amie_pkg, amie_stream_if and the checker.
`timescale 1ns / 1ps
module array_machine_instruction_executor_tb;
    import amie_pkg::*;

    localparam int IDLE_LIMIT = 300000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        idle_on = 1'b1;
    int          fail_count;
    int          pending;
    int          exec_count;
    int          char_count;
    int          quiet_cycles = 0;
    logic [31:0] program_words [$];

    amie_stream_if #(.T(t_in_item))  in_ch ();
    amie_stream_if #(.T(t_out_item)) out_ch ();

    array_machine_instruction_executor i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    array_machine_instruction_executor_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_exec_count (exec_count),
        .o_char_count (char_count)
    );

    always #2 i_clk = ~i_clk;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
    end

    always @(negedge i_clk) begin
        out_ch.ready <= idle_on ? ($urandom_range(99) >= 16) : 1'b1;
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("Watchdog: no transaction for %0d cycles", IDLE_LIMIT);
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [31:0] instr(input logic [3:0] op, input int a, input int b,
                                          input int c);
        return {op, 19'($urandom), 3'(a), 3'(b), 3'(c)};
    endfunction

    function automatic void put_imm(input int r, input logic [24:0] v);
        program_words.push_back({OP_IMM, 3'(r), v});
    endfunction

    function automatic int work_reg();
        return $urandom_range(4);
    endfunction

    function automatic void put_block();
        int n;
        case ($urandom_range(9))
            0: program_words.push_back(instr(OP_CMOV, work_reg(), $urandom_range(7),
                                             $urandom_range(7)));
            1: program_words.push_back(instr(OP_ADD, work_reg(), $urandom_range(7),
                                             $urandom_range(7)));
            2: program_words.push_back(instr(OP_MUL, work_reg(), $urandom_range(7),
                                             $urandom_range(7)));
            3: program_words.push_back(instr(OP_NAND, work_reg(), $urandom_range(7),
                                             $urandom_range(7)));
            4: put_imm(work_reg(), 25'($urandom));
            5: program_words.push_back(instr(OP_INPUT, 0, 0, work_reg()));
            6: begin
                put_imm(5, ($urandom_range(1)) ? 25'($urandom_range(1, 33554431))
                                               : 25'($urandom_range(1, 9)));
                program_words.push_back(instr(OP_DIV, work_reg(), $urandom_range(7), 5));
            end
            7: begin
                put_imm(5, 25'($urandom_range(255)));
                program_words.push_back(instr(OP_OUTPUT, 0, 0, 5));
            end
            8: begin
                n = $urandom_range(1, 8);
                put_imm(5, 25'(n));
                program_words.push_back(instr(OP_ALLOC, 0, 7, 5));
                put_imm(6, 25'($urandom_range(n - 1)));
                program_words.push_back(instr(OP_AMEND, 7, 6, $urandom_range(4)));
                program_words.push_back(instr(OP_INDEX, work_reg(), 7, 6));
                if ($urandom_range(1)) program_words.push_back(instr(OP_FREE, 0, 0, 7));
            end
            default: begin
                put_imm(6, 25'd0);
                put_imm(5, 25'(program_words.size() + 3));
                program_words.push_back(instr(OP_LOADPROG, 0, 6, 5));
            end
        endcase
    endfunction

    function automatic void put_ending();
        case ($urandom_range(8))
            0: program_words.push_back(instr(OP_HALT, 0, 0, 0));
            1: begin
                put_imm(5, 25'd0);
                program_words.push_back(instr(OP_DIV, 0, 1, 5));
            end
            2: begin
                put_imm(5, 25'($urandom_range(256, 33554431)));
                program_words.push_back(instr(OP_OUTPUT, 0, 0, 5));
            end
            3: begin
                put_imm(5, 25'd0);
                program_words.push_back(instr(OP_FREE, 0, 0, 5));
            end
            4: program_words.push_back({($urandom_range(1) ? 4'd14 : 4'd15), 28'($urandom)});
            5: begin
                put_imm(5, 25'($urandom_range(1024, 33554431)));
                program_words.push_back(instr(OP_INDEX, 0, 5, 0));
            end
            6: begin
                put_imm(5, 25'd2);
                program_words.push_back(instr(OP_ALLOC, 0, 7, 5));
                put_imm(6, 25'd2);
                program_words.push_back(instr(OP_INDEX, 0, 7, 6));
            end
            7: begin
                put_imm(5, 25'd0);
                program_words.push_back(instr(OP_ALLOC, 0, 7, 5));
                program_words.push_back(instr(OP_LOADPROG, 0, 7, 5));
            end
            default: ;
        endcase
    endfunction

    task automatic send_item(input t_in_item it);
        while (idle_on && $urandom_range(99) < 16) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= it;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    function automatic t_in_item make_step();
        t_in_item it;
        it.cmd = CMD_EXEC;
        it.load_word = $urandom;
        it.in_char = $urandom_range(255);
        it.in_eof = ($urandom_range(4) == 0);
        return it;
    endfunction

    initial begin
        t_in_item it;
        int       steps;
        // Directed opening: operand extremes, every plain operation and an empty array.
        put_imm(0, 25'h1FF_FFFF);
        put_imm(1, 25'd0);
        program_words.push_back(instr(OP_ADD, 2, 0, 0));
        program_words.push_back(instr(OP_MUL, 3, 0, 0));
        program_words.push_back(instr(OP_NAND, 4, 1, 1));
        program_words.push_back(instr(OP_ADD, 3, 4, 4));
        program_words.push_back(instr(OP_CMOV, 2, 0, 1));
        program_words.push_back(instr(OP_CMOV, 2, 4, 0));
        program_words.push_back(instr(OP_INPUT, 0, 0, 3));
        put_imm(5, 25'd1);
        program_words.push_back(instr(OP_DIV, 2, 4, 5));
        put_imm(5, 25'd0);
        program_words.push_back(instr(OP_OUTPUT, 0, 0, 5));
        program_words.push_back(instr(OP_ALLOC, 0, 7, 5));
        put_imm(5, 25'd255);
        program_words.push_back(instr(OP_OUTPUT, 0, 0, 5));
        put_imm(6, 25'd0);
        put_imm(5, 25'(program_words.size() + 2));
        program_words.push_back(instr(OP_LOADPROG, 0, 6, 5));
        while (program_words.size() < 260) put_block();
        put_ending();

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (program_words[i]) begin
            it = make_step();
            it.cmd = CMD_LOAD;
            it.load_word = program_words[i];
            send_item(it);
        end
        steps = program_words.size() + 6;
        for (int i = 0; i < steps; i++) begin
            idle_on <= !(i >= 60 && i < 180);
            it = make_step();
            if (i % 50 == 25) it.cmd = CMD_LOAD;
            send_item(it);
        end
        in_ch.valid <= 1'b0;
        idle_on <= 1'b1;

        while (pending != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
        $display("Loaded %0d program words and sent %0d execute transactions.",
                 program_words.size(), exec_count);
        $display("Predicted %0d output characters along the way.", char_count);
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/amie_pkg.sv
hw/rtl/amie_stream_if.sv
hw/rtl/amie_dp.sv
hw/rtl/amie_ctrl.sv
hw/rtl/array_machine_instruction_executor.sv
verif/array_machine_instruction_executor_checker.sv
verif/array_machine_instruction_executor_tb.sv
